/* rtl/bat_pkg.sv */
// Shared constants and types for the block address translation unit.
package bat_pkg;

  // Entry pairs held per side (instruction and data)
  localparam int EntryPairs = 4;

  // Address split: 15-bit page index above a 17-bit offset
  localparam int PageShift = 17;
  localparam int PageW     = 15;
  localparam int MaskW     = 11;
  localparam int AttrW     = 4;
  localparam int AddrW     = 32;
  localparam int WordW     = 32;
  localparam int IdxW      = 2;

  // Operation codes
  localparam logic [1:0] OpTranslate = 2'd0;
  localparam logic [1:0] OpLoadUpper = 2'd1;
  localparam logic [1:0] OpLoadLower = 2'd2;

  // Page bits that the block-length mask never covers
  localparam logic [PageW-1:0] FixedPageBits = 15'h7800;

  // Attributes (W I M G) returned with translation off
  localparam logic [AttrW-1:0] AttrFetchOff = 4'h1;
  localparam logic [AttrW-1:0] AttrDataOff  = 4'h3;

  // Table write request
  typedef struct packed {
    logic             en;
    logic             upper;
    logic             fetch;
    logic [IdxW-1:0]  idx;
    logic [WordW-1:0] word;
  } bat_wr_t;

  // Per-entry lookup result
  typedef struct packed {
    logic             match;
    logic [PageW-1:0] page;
    logic [AttrW-1:0] attr;
  } bat_cand_t;

endpackage

/* rtl/block_address_translation.sv */
// Top level of the block address translation unit: three-stage lookup pipeline.
//
// Translates one address per cycle when the output is not stalled:
// stage one registers the request, stage two holds the masked page
// compare of every entry, stage three holds the priority pick and
// the composed physical address. Each stage advances when it is empty or the one
// after it moves, so a stalled output only backs up as far as the pipeline is
// full. Load beats write their entry word at acceptance and give no result; a
// translate accepted later sees the new word, one accepted earlier does not.
// Unused operation codes are taken and dropped. Reset clears all entries at once.
module block_address_translation (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  operation_i,
  input  logic                        instruction_side_i,
  input  logic [bat_pkg::IdxW-1:0]    entry_index_i,
  input  logic [bat_pkg::WordW-1:0]   entry_word_i,
  input  logic [bat_pkg::AddrW-1:0]   effective_address_i,
  input  logic                        translation_on_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic [bat_pkg::AddrW-1:0]   physical_address_o,
  output logic [bat_pkg::AttrW-1:0]   storage_attributes_o
);
  import bat_pkg::*;

  logic      accept;
  logic      rdy1, rdy2, rdy3;
  bat_wr_t   tbl_wr;
  bat_cand_t cand1 [EntryPairs];

  // Stage 1: registered request
  logic             v1_q;
  logic [AddrW-1:0] ea1_q;
  logic             side1_q;
  logic             on1_q;

  // Stage 2: compare results
  logic             v2_q;
  logic [AddrW-1:0] ea2_q;
  logic             side2_q;
  logic             on2_q;
  bat_cand_t        cand2_q [EntryPairs];

  // Stage 3: output register
  logic             v3_q;
  logic             hit3_q, hit3_d;
  logic [AddrW-1:0] pa3_q, pa3_d;
  logic [AttrW-1:0] attr3_q, attr3_d;

  // Backpressure chain
  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign accept     = in_valid_i && in_ready_o;

  // Entry loads
  always_comb begin
    tbl_wr.en    = accept && ((operation_i == OpLoadUpper) || (operation_i == OpLoadLower)) &&
                   (int'(entry_index_i) < EntryPairs);
    tbl_wr.upper = (operation_i == OpLoadUpper);
    tbl_wr.fetch = instruction_side_i;
    tbl_wr.idx   = entry_index_i;
    tbl_wr.word  = entry_word_i;
  end

  bat_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tbl_wr),
    .fetch_i   (side1_q),
    .ea_page_i (ea1_q[AddrW-1:PageShift]),
    .cand_o    (cand1)
  );

  // Stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= accept && (operation_i == OpTranslate);
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      ea1_q   <= effective_address_i;
      side1_q <= instruction_side_i;
      on1_q   <= translation_on_i;
    end
    if (rdy2) begin
      ea2_q   <= ea1_q;
      side2_q <= side1_q;
      on2_q   <= on1_q;
      cand2_q <= cand1;
    end
    if (rdy3) begin
      hit3_q  <= hit3_d;
      pa3_q   <= pa3_d;
      attr3_q <= attr3_d;
    end
  end

  // First matching entry wins; pass-through when translation is off
  always_comb begin
    logic [PageW-1:0] page;
    logic             found;
    logic [AttrW-1:0] attr;
    found = 1'b0;
    page  = '0;
    attr  = '0;
    for (int k = EntryPairs - 1; k >= 0; k--) begin
      if (cand2_q[k].match) begin
        found = 1'b1;
        page  = cand2_q[k].page;
        attr  = cand2_q[k].attr;
      end
    end
    if (!on2_q) begin
      hit3_d  = 1'b1;
      pa3_d   = ea2_q;
      attr3_d = side2_q ? AttrFetchOff : AttrDataOff;
    end else if (found) begin
      hit3_d  = 1'b1;
      pa3_d   = {page, ea2_q[PageShift-1:0]};
      attr3_d = attr;
    end else begin
      hit3_d  = 1'b0;
      pa3_d   = '0;
      attr3_d = '0;
    end
  end

  assign out_valid_o          = v3_q;
  assign hit_o                = hit3_q;
  assign physical_address_o   = pa3_q;
  assign storage_attributes_o = attr3_q;

endmodule

/* rtl/bat_table.sv */
// Entry storage for both sides plus the per-entry page compare.
module bat_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bat_pkg::bat_wr_t               wr_i,
  input  logic                           fetch_i,
  input  logic [bat_pkg::PageW-1:0]      ea_page_i,
  output bat_pkg::bat_cand_t             cand_o [bat_pkg::EntryPairs]
);
  import bat_pkg::*;

  logic [WordW-1:0] fetch_upper_q [EntryPairs];
  logic [WordW-1:0] fetch_lower_q [EntryPairs];
  logic [WordW-1:0] data_upper_q  [EntryPairs];
  logic [WordW-1:0] data_lower_q  [EntryPairs];

  // Entry words; reset leaves every entry invalid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < EntryPairs; k++) begin
        fetch_upper_q[k] <= '0;
        fetch_lower_q[k] <= '0;
        data_upper_q[k]  <= '0;
        data_lower_q[k]  <= '0;
      end
    end else if (wr_i.en) begin
      for (int k = 0; k < EntryPairs; k++) begin
        if (int'(wr_i.idx) == k) begin
          if (wr_i.upper && wr_i.fetch)   fetch_upper_q[k] <= wr_i.word;
          if (wr_i.upper && !wr_i.fetch)  data_upper_q[k]  <= wr_i.word;
          if (!wr_i.upper && wr_i.fetch)  fetch_lower_q[k] <= wr_i.word;
          if (!wr_i.upper && !wr_i.fetch) data_lower_q[k]  <= wr_i.word;
        end
      end
    end
  end

  // Masked compare and candidate page for each entry of the selected side
  for (genvar k = 0; k < EntryPairs; k++) begin : g_entry
    logic [WordW-1:0] upper_w;
    logic [WordW-1:0] lower_w;
    logic [MaskW-1:0] len_mask;
    logic [PageW-1:0] probe;

    assign upper_w  = fetch_i ? fetch_upper_q[k] : data_upper_q[k];
    assign lower_w  = fetch_i ? fetch_lower_q[k] : data_lower_q[k];
    assign len_mask = upper_w[12:2];
    assign probe    = ea_page_i & (FixedPageBits | {{(PageW-MaskW){1'b0}}, ~len_mask});

    assign cand_o[k].match = (|upper_w[1:0]) && (probe == upper_w[31:PageShift]);
    assign cand_o[k].page  = lower_w[31:PageShift] |
                             (ea_page_i & {{(PageW-MaskW){1'b0}}, len_mask});
    assign cand_o[k].attr  = lower_w[6:3];
  end

endmodule

/* rtl/bat_checker.sv */
// Port-level checks for the block address translation unit, bound to the top level.
module bat_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      hit_o,
  input logic [bat_pkg::AddrW-1:0] physical_address_o,
  input logic [bat_pkg::AttrW-1:0] storage_attributes_o
);
  import bat_pkg::*;

  logic drain;
  assign drain = out_ready_i && !(in_valid_i && in_ready_o);

  // A miss carries an all-zero address and attributes
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (physical_address_o == '0 && storage_attributes_o == '0))
    else $error("miss beat with nonzero payload");

  // Input backs up only when a result is waiting at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // Draining, with the output ready and no beat accepted, empties every stage of the pipeline
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain ##1 drain ##1 drain |=> !out_valid_o)
    else $error("result beat without a recent request");

  // A waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(hit_o) && $stable(physical_address_o) &&
       $stable(storage_attributes_o)))
    else $error("stalled result beat changed");

endmodule

bind block_address_translation bat_checker u_bat_checker (.*);
